FILE: rtl/sbct_pkg.sv
package sbct_pkg;

  localparam int COORD_BITS     = 16;
  localparam int TIME_FRAC_BITS = 16;
  localparam int SIZE_BITS      = 15;
  localparam int VEL_BITS       = 24;
  localparam int VEL_FRAC       = 8;

  // gap width: coordinate plus size plus difference
  localparam int GW  = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
  localparam int GMW = GW - 1;
  localparam int DW  = VEL_BITS;
  // quotient bits: integer part below 8.0 plus fraction
  localparam int QW  = TIME_FRAC_BITS + 3;
  localparam int PRE_SHIFT = VEL_FRAC - 3;
  localparam int IW  = GMW + PRE_SHIFT;
  localparam int CW  = (IW > DW) ? IW : DW;
  localparam int TSW = TIME_FRAC_BITS + 5;
  localparam int TW  = TIME_FRAC_BITS + 1;

  localparam int LANES      = 4;
  localparam int LANE_X_IN  = 0;
  localparam int LANE_X_OUT = 1;
  localparam int LANE_Y_IN  = 2;
  localparam int LANE_Y_OUT = 3;

  localparam logic signed [TSW-1:0] T_ONE = TSW'(64'sd1 <<< TIME_FRAC_BITS);
  localparam logic signed [TSW-1:0] T_SAT = TSW'(64'sd8 <<< TIME_FRAC_BITS);

  localparam logic signed [1:0] NORM_POS  = 2'sd1;
  localparam logic signed [1:0] NORM_NEG  = -2'sd1;
  localparam logic signed [1:0] NORM_ZERO = 2'sd0;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] dvs;
    logic [QW-1:0] quo;
    logic          neg;
    logic          sat;
    logic          vzero;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic              gx_neg;
    logic              gy_neg;
  } item_t;

endpackage

FILE: rtl/swept_box_collision_time.sv
// Swept box collision time. Each request carries a moving box A, its Q15.8
// velocity and a static box B; the block returns the first contact time in
// unsigned Q1.16 (65536 = no hit within the step), the normal of the struck
// side of B and a collided flag. One request is taken every clock while the
// result side keeps up. The pipeline is a gap/setup stage, a row of
// 19 divider cells that each settle one quotient bit for all four entry and
// exit divisions at once, a time-forming stage and a compare/output register.
// A stall on the result side holds the whole pipeline, so in_stall follows
// out_stall whenever a result is waiting.
module swept_box_collision_time (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sbct_pkg::COORD_BITS-1:0] in_a_x,
  input  logic signed [sbct_pkg::COORD_BITS-1:0] in_a_y,
  input  logic [sbct_pkg::SIZE_BITS-1:0]         in_a_w,
  input  logic [sbct_pkg::SIZE_BITS-1:0]         in_a_h,
  input  logic signed [sbct_pkg::VEL_BITS-1:0]   in_vel_x,
  input  logic signed [sbct_pkg::VEL_BITS-1:0]   in_vel_y,
  input  logic signed [sbct_pkg::COORD_BITS-1:0] in_b_x,
  input  logic signed [sbct_pkg::COORD_BITS-1:0] in_b_y,
  input  logic [sbct_pkg::SIZE_BITS-1:0]         in_b_w,
  input  logic [sbct_pkg::SIZE_BITS-1:0]         in_b_h,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [sbct_pkg::TW-1:0]                out_contact_time,
  output logic signed [1:0]                      out_normal_x,
  output logic signed [1:0]                      out_normal_y,
  output logic                                   out_collided
);

  logic            adv;
  logic            vld [0:sbct_pkg::QW];
  sbct_pkg::item_t item [0:sbct_pkg::QW];

  // advance everything unless a finished result is being held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // form gaps, magnitudes and saturation flags
  sbct_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .a_x    (in_a_x),
    .a_y    (in_a_y),
    .a_w    (in_a_w),
    .a_h    (in_a_h),
    .vel_x  (in_vel_x),
    .vel_y  (in_vel_y),
    .b_x    (in_b_x),
    .b_y    (in_b_y),
    .b_w    (in_b_w),
    .b_h    (in_b_h),
    .vld_r  (vld[0]),
    .item_r (item[0])
  );

  // one quotient bit per cell, MSB first
  for (genvar i = 0; i < sbct_pkg::QW; i++) begin : g_cell
    sbct_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (vld[i]),
      .in_item (item[i]),
      .vld_r   (vld[i+1]),
      .item_r  (item[i+1])
    );
  end

  // apply sign and rounding, then pick contact time and normal
  sbct_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (vld[sbct_pkg::QW]),
    .in_item   (item[sbct_pkg::QW]),
    .out_vld_r (out_valid),
    .time_r    (out_contact_time),
    .nx_r      (out_normal_x),
    .ny_r      (out_normal_y),
    .hit_r     (out_collided)
  );

endmodule

FILE: rtl/sbct_prep.sv
module sbct_prep (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_vld,
  input  logic signed [sbct_pkg::COORD_BITS-1:0] a_x,
  input  logic signed [sbct_pkg::COORD_BITS-1:0] a_y,
  input  logic [sbct_pkg::SIZE_BITS-1:0]      a_w,
  input  logic [sbct_pkg::SIZE_BITS-1:0]      a_h,
  input  logic signed [sbct_pkg::VEL_BITS-1:0] vel_x,
  input  logic signed [sbct_pkg::VEL_BITS-1:0] vel_y,
  input  logic signed [sbct_pkg::COORD_BITS-1:0] b_x,
  input  logic signed [sbct_pkg::COORD_BITS-1:0] b_y,
  input  logic [sbct_pkg::SIZE_BITS-1:0]      b_w,
  input  logic [sbct_pkg::SIZE_BITS-1:0]      b_h,
  output logic                                vld_r,
  output sbct_pkg::item_t                     item_r
);

  function automatic sbct_pkg::lane_t mk_lane(
    input logic signed [sbct_pkg::GW-1:0] g,
    input logic signed [sbct_pkg::DW-1:0] v
  );
    sbct_pkg::lane_t l;
    logic [sbct_pkg::GMW-1:0] g_abs;
    logic [sbct_pkg::IW-1:0]  init;
    g_abs   = g[sbct_pkg::GW-1] ? sbct_pkg::GMW'(-g) : sbct_pkg::GMW'(g);
    init    = {g_abs, {sbct_pkg::PRE_SHIFT{1'b0}}};
    l.dvs   = v[sbct_pkg::DW-1] ? sbct_pkg::DW'(-v) : sbct_pkg::DW'(v);
    l.sat   = sbct_pkg::CW'(init) >= sbct_pkg::CW'(l.dvs);
    l.rem   = sbct_pkg::DW'(init);
    l.quo   = '0;
    l.neg   = g[sbct_pkg::GW-1] ^ v[sbct_pkg::DW-1];
    l.vzero = (v == '0);
    return l;
  endfunction

  logic signed [sbct_pkg::GW-1:0] ax, ay, bx, by, aw, ah, bw, bh;
  logic signed [sbct_pkg::GW-1:0] nx, fx, ny, fy, gx_in, gx_out, gy_in, gy_out;
  logic                           vx_pos, vy_pos;
  sbct_pkg::item_t                item_nxt;

  always_comb begin
    ax = sbct_pkg::GW'(a_x);
    ay = sbct_pkg::GW'(a_y);
    bx = sbct_pkg::GW'(b_x);
    by = sbct_pkg::GW'(b_y);
    aw = $signed(sbct_pkg::GW'(a_w));
    ah = $signed(sbct_pkg::GW'(a_h));
    bw = $signed(sbct_pkg::GW'(b_w));
    bh = $signed(sbct_pkg::GW'(b_h));
    nx = bx - (ax + aw);
    fx = (bx + bw) - ax;
    ny = by - (ay + ah);
    fy = (by + bh) - ay;
    vx_pos = !vel_x[sbct_pkg::DW-1] && (vel_x != '0);
    vy_pos = !vel_y[sbct_pkg::DW-1] && (vel_y != '0);
    // order gaps by direction of travel
    gx_in  = vx_pos ? nx : fx;
    gx_out = vx_pos ? fx : nx;
    gy_in  = vy_pos ? ny : fy;
    gy_out = vy_pos ? fy : ny;
    item_nxt.lane[sbct_pkg::LANE_X_IN]  = mk_lane(gx_in, vel_x);
    item_nxt.lane[sbct_pkg::LANE_X_OUT] = mk_lane(gx_out, vel_x);
    item_nxt.lane[sbct_pkg::LANE_Y_IN]  = mk_lane(gy_in, vel_y);
    item_nxt.lane[sbct_pkg::LANE_Y_OUT] = mk_lane(gy_out, vel_y);
    item_nxt.gx_neg = gx_in[sbct_pkg::GW-1];
    item_nxt.gy_neg = gy_in[sbct_pkg::GW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/sbct_div_cell.sv
module sbct_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  sbct_pkg::item_t in_item,
  output logic            vld_r,
  output sbct_pkg::item_t item_r
);

  sbct_pkg::item_t item_nxt;

  // one restoring quotient bit per lane
  always_comb begin
    logic [sbct_pkg::DW:0] t;
    logic                  ge;
    item_nxt = in_item;
    for (int i = 0; i < sbct_pkg::LANES; i++) begin
      t  = {in_item.lane[i].rem, 1'b0};
      ge = t >= {1'b0, in_item.lane[i].dvs};
      item_nxt.lane[i].rem = ge ? sbct_pkg::DW'(t - {1'b0, in_item.lane[i].dvs})
                                : sbct_pkg::DW'(t);
      item_nxt.lane[i].quo = {in_item.lane[i].quo[sbct_pkg::QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/sbct_resolve.sv
module sbct_resolve (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  sbct_pkg::item_t               in_item,
  output logic                          out_vld_r,
  output logic [sbct_pkg::TW-1:0]       time_r,
  output logic signed [1:0]             nx_r,
  output logic signed [1:0]             ny_r,
  output logic                          hit_r
);

  function automatic logic signed [sbct_pkg::TSW-1:0] time_of(
    input sbct_pkg::lane_t l,
    input logic            entry
  );
    logic signed [sbct_pkg::TSW-1:0] mag;
    logic signed [sbct_pkg::TSW-1:0] res;
    mag = $signed(sbct_pkg::TSW'(l.quo));
    if (l.vzero) begin
      res = entry ? -sbct_pkg::T_SAT : sbct_pkg::T_SAT;
    end else if (l.sat) begin
      res = l.neg ? -sbct_pkg::T_SAT : sbct_pkg::T_SAT;
    end else if (l.neg) begin
      res = -(mag + $signed(sbct_pkg::TSW'(l.rem != '0)));
    end else begin
      res = mag;
    end
    return res;
  endfunction

  logic                            vld_r;
  logic signed [sbct_pkg::TSW-1:0] tx_in_r, tx_out_r, ty_in_r, ty_out_r;
  logic                            gx_neg_r, gy_neg_r;
  logic signed [sbct_pkg::TSW-1:0] t_in, t_out;
  logic                            x_later, no_hit;
  logic [sbct_pkg::TW-1:0]         time_nxt;
  logic signed [1:0]               nx_nxt, ny_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= in_vld;
      out_vld_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_in_r  <= time_of(in_item.lane[sbct_pkg::LANE_X_IN], 1'b1);
      tx_out_r <= time_of(in_item.lane[sbct_pkg::LANE_X_OUT], 1'b0);
      ty_in_r  <= time_of(in_item.lane[sbct_pkg::LANE_Y_IN], 1'b1);
      ty_out_r <= time_of(in_item.lane[sbct_pkg::LANE_Y_OUT], 1'b0);
      gx_neg_r <= in_item.gx_neg;
      gy_neg_r <= in_item.gy_neg;
      time_r   <= time_nxt;
      nx_r     <= nx_nxt;
      ny_r     <= ny_nxt;
      hit_r    <= !no_hit;
    end
  end

  always_comb begin
    x_later = tx_in_r > ty_in_r;
    t_in    = x_later ? tx_in_r : ty_in_r;
    t_out   = (tx_out_r < ty_out_r) ? tx_out_r : ty_out_r;
    no_hit  = (t_in > t_out) || (tx_in_r < 0 && ty_in_r < 0) ||
              (tx_in_r > sbct_pkg::T_ONE) || (ty_in_r > sbct_pkg::T_ONE);
    nx_nxt  = sbct_pkg::NORM_ZERO;
    ny_nxt  = sbct_pkg::NORM_ZERO;
    if (no_hit) begin
      time_nxt = sbct_pkg::TW'(sbct_pkg::T_ONE);
    end else begin
      time_nxt = sbct_pkg::TW'(t_in);
      if (x_later) begin
        nx_nxt = gx_neg_r ? sbct_pkg::NORM_POS : sbct_pkg::NORM_NEG;
      end else begin
        ny_nxt = gy_neg_r ? sbct_pkg::NORM_POS : sbct_pkg::NORM_NEG;
      end
    end
  end

endmodule

FILE: dv/swept_box_collision_time_test.sv
`timescale 1ns / 100ps

module swept_box_collision_time_test;

  localparam int LATENCY = 22;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [sbct_pkg::COORD_BITS-1:0] in_a_x, in_a_y, in_b_x, in_b_y;
  logic [sbct_pkg::SIZE_BITS-1:0] in_a_w, in_a_h, in_b_w, in_b_h;
  logic signed [sbct_pkg::VEL_BITS-1:0] in_vel_x, in_vel_y;
  logic out_valid;
  logic out_stall;
  logic [sbct_pkg::TW-1:0] out_contact_time;
  logic signed [1:0] out_normal_x, out_normal_y;
  logic out_collided;

  typedef struct packed {
    logic [sbct_pkg::TW-1:0] contact_time;
    logic signed [1:0] normal_x;
    logic signed [1:0] normal_y;
    logic collided;
  } contact_t;

  contact_t pending_contacts[$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;

  swept_box_collision_time u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_w(in_a_w), .in_a_h(in_a_h),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_w(in_b_w), .in_b_h(in_b_h),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_contact_time(out_contact_time), .out_normal_x(out_normal_x),
    .out_normal_y(out_normal_y), .out_collided(out_collided)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Floor of gap * 2^16 / (vel / 2^8), saturated to +/- 8.0; vel is nonzero.
  function automatic longint gap_time(longint gap, longint vel);
    longint n;
    longint d;
    longint q;
    longint one;
    one = longint'(1) << sbct_pkg::TIME_FRAC_BITS;
    n = (gap < 0 ? -gap : gap) << sbct_pkg::VEL_FRAC;
    d = vel < 0 ? -vel : vel;
    if (n >= 8 * d) return ((gap < 0) != (vel < 0)) ? -8 * one : 8 * one;
    q = (n << sbct_pkg::TIME_FRAC_BITS) / d;
    if ((gap < 0) != (vel < 0)) begin
      if (((n << sbct_pkg::TIME_FRAC_BITS) % d) != 0) q = q + 1;
      return -q;
    end
    return q;
  endfunction

  function automatic contact_t predict_contact(
      longint ax, longint ay, longint aw, longint ah, longint vx, longint vy,
      longint bx, longint by, longint bw, longint bh);
    longint gx_in, gx_out, gy_in, gy_out;
    longint tx_in, tx_out, ty_in, ty_out, t_in, t_out;
    longint one, sat;
    contact_t c;
    one = longint'(1) << sbct_pkg::TIME_FRAC_BITS;
    sat = 8 * one;
    if (vx > 0) begin
      gx_in = bx - (ax + aw);
      gx_out = (bx + bw) - ax;
    end else begin
      gx_in = (bx + bw) - ax;
      gx_out = bx - (ax + aw);
    end
    if (vy > 0) begin
      gy_in = by - (ay + ah);
      gy_out = (by + bh) - ay;
    end else begin
      gy_in = (by + bh) - ay;
      gy_out = by - (ay + ah);
    end
    tx_in = (vx == 0) ? -sat : gap_time(gx_in, vx);
    tx_out = (vx == 0) ? sat : gap_time(gx_out, vx);
    ty_in = (vy == 0) ? -sat : gap_time(gy_in, vy);
    ty_out = (vy == 0) ? sat : gap_time(gy_out, vy);
    t_in = tx_in > ty_in ? tx_in : ty_in;
    t_out = tx_out < ty_out ? tx_out : ty_out;
    c.normal_x = sbct_pkg::NORM_ZERO;
    c.normal_y = sbct_pkg::NORM_ZERO;
    if (t_in > t_out || (tx_in < 0 && ty_in < 0) || tx_in > one || ty_in > one) begin
      c.contact_time = sbct_pkg::TW'(one);
      c.collided = 1'b0;
    end else begin
      c.contact_time = sbct_pkg::TW'(t_in);
      c.collided = 1'b1;
      if (tx_in > ty_in) c.normal_x = gx_in < 0 ? sbct_pkg::NORM_POS : sbct_pkg::NORM_NEG;
      else c.normal_y = gy_in < 0 ? sbct_pkg::NORM_POS : sbct_pkg::NORM_NEG;
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Drive one request, hold it until accepted, record its predicted contact.
  task automatic send_boxes(int ax, int ay, int aw, int ah, int vx, int vy,
                            int bx, int by, int bw, int bh);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a_x <= sbct_pkg::COORD_BITS'(ax);
    in_a_y <= sbct_pkg::COORD_BITS'(ay);
    in_a_w <= sbct_pkg::SIZE_BITS'(aw);
    in_a_h <= sbct_pkg::SIZE_BITS'(ah);
    in_vel_x <= sbct_pkg::VEL_BITS'(vx);
    in_vel_y <= sbct_pkg::VEL_BITS'(vy);
    in_b_x <= sbct_pkg::COORD_BITS'(bx);
    in_b_y <= sbct_pkg::COORD_BITS'(by);
    in_b_w <= sbct_pkg::SIZE_BITS'(bw);
    in_b_h <= sbct_pkg::SIZE_BITS'(bh);
    pending_contacts.push_back(predict_contact(
        longint'($signed(sbct_pkg::COORD_BITS'(ax))),
        longint'($signed(sbct_pkg::COORD_BITS'(ay))),
        aw & 32'h7fff, ah & 32'h7fff,
        longint'($signed(sbct_pkg::VEL_BITS'(vx))),
        longint'($signed(sbct_pkg::VEL_BITS'(vy))),
        longint'($signed(sbct_pkg::COORD_BITS'(bx))),
        longint'($signed(sbct_pkg::COORD_BITS'(by))),
        bw & 32'h7fff, bh & 32'h7fff));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    contact_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("unexpected result", out_contact_time, -1);
      end else begin
        want = pending_contacts.pop_front();
        if (out_contact_time !== want.contact_time)
          report_mismatch("contact_time", out_contact_time, want.contact_time);
        if (out_normal_x !== want.normal_x)
          report_mismatch("normal_x", out_normal_x, want.normal_x);
        if (out_normal_y !== want.normal_y)
          report_mismatch("normal_y", out_normal_y, want.normal_y);
        if (out_collided !== want.collided)
          report_mismatch("collided", out_collided, want.collided);
      end
    end
  end

  // Receiver backpressure at the current rate.
  always @(posedge clk) begin
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk);
  endtask

  // Extremes of fields, zero velocities, both axes, signs, near-integer quotients.
  task automatic test_directed();
    send_boxes(0, 0, 10, 10, 0, 0, 100, 100, 10, 10);
    send_boxes(0, 0, 10, 10, 200 << 8, 0, 100, 0, 10, 10);
    send_boxes(200, 0, 10, 10, -(200 << 8), 0, 100, 0, 10, 10);
    send_boxes(0, 0, 10, 10, 0, 200 << 8, 0, 100, 10, 10);
    send_boxes(0, 200, 10, 10, 0, -(200 << 8), 0, 100, 10, 10);
    send_boxes(0, 0, 10, 10, 100 << 8, 100 << 8, 50, 60, 10, 10);
    send_boxes(0, 0, 10, 10, 100 << 8, 100 << 8, 60, 50, 10, 10);
    send_boxes(0, 0, 10, 10, 90 << 8, 0, 100, 0, 10, 10);
    send_boxes(0, 0, 10, 10, (90 << 8) - 1, 0, 100, 0, 10, 10);
    send_boxes(0, 0, 10, 10, (90 << 8) + 1, 0, 100, 0, 10, 10);
    send_boxes(0, 0, 10, 10, 3, 0, 100, 0, 10, 10);
    send_boxes(5, 5, 10, 10, 0, 0, 0, 0, 10, 10);
    send_boxes(-32768, -32768, 32767, 32767, 8388607, 8388607, 32767, 32767,
               32767, 32767);
    send_boxes(32767, 32767, 32767, 32767, -8388608, -8388608, -32768, -32768,
               32767, 32767);
    send_boxes(-32768, 32767, 0, 0, 8388607, -8388608, 32767, -32768, 0, 0);
    send_boxes(0, 0, 0, 0, 1, -1, 0, 0, 0, 0);
    send_boxes(0, 0, 10, 10, 50 << 8, -(50 << 8), 20, -30, 10, 10);
    send_boxes(0, 0, 10, 10, 30 << 8, 0, 20, 30, 10, 10);
    send_boxes(-100, 0, 10, 10, -(50 << 8), 0, 0, 0, 10, 10);
    send_boxes(0, 0, 10, 10, -(7 << 8), 3 << 8, 13, 0, 10, 10);
  endtask

  // Mostly nearby pairs with bounded sizes and velocities; some pure noise.
  task automatic test_random(int count);
    int ax, ay, bx, by, vx, vy;
    repeat (count) begin
      if ($urandom_range(9) < 2) begin
        send_boxes($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      end else begin
        ax = $urandom_range(400) - 200;
        ay = $urandom_range(400) - 200;
        bx = $urandom_range(400) - 200;
        by = $urandom_range(400) - 200;
        vx = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(160000)) - 80000;
        vy = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(160000)) - 80000;
        send_boxes(ax, ay, $urandom_range(60), $urandom_range(60), vx, vy,
                   bx, by, $urandom_range(60), $urandom_range(60));
      end
    end
  endtask

  task automatic test_drain_pause();
    send_boxes(0, 0, 10, 10, 200 << 8, 0, 100, 0, 10, 10);
    drain_results();
    test_random(20);
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {in_a_x, in_a_y, in_a_w, in_a_h, in_vel_x, in_vel_y} = '0;
    {in_b_x, in_b_y, in_b_w, in_b_h} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 35;
    recv_idle_pct = 58;
    test_directed();
    test_random(500);
    send_idle_pct = 58;
    recv_idle_pct = 35;
    test_drain_pause();
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(560);
    drain_results();
    repeat (LATENCY + 5) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
